// File: rtl/spkv_pkg.sv
// ----------------------------------------------------------------------------
// spkv_pkg
// Shared types and constants of the slotted page key/value store.
// ----------------------------------------------------------------------------
package spkv_pkg;

  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int ENTRY_BYTES      = 8;

  typedef enum logic [2:0] {
    FN_CLEAR   = 3'd0,
    FN_STAGE   = 3'd1,
    FN_INSERT  = 3'd2,
    FN_UPDATE  = 3'd3,
    FN_DELETE  = 3'd4,
    FN_COMPACT = 3'd5,
    FN_LOOKUP  = 3'd6,
    FN_FETCH   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_NO_SPACE     = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_TOO_SMALL    = 3'd5,
    ST_STAGING_FULL = 3'd6,
    ST_UNWRITTEN    = 3'd7
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [7:0]  data_byte;
    logic [12:0] read_limit;
    logic [11:0] byte_address;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  entry_index;
    logic [11:0] value_addr;
    logic [11:0] value_size;
    logic [7:0]  data_out;
    logic [8:0]  entry_total;
    logic [11:0] free_space;
  } res_t;

endpackage

// File: rtl/slotted_page_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// slotted_page_key_value_store_unit
// One leaf page: sorted key directory plus a downward-growing value store.
// ----------------------------------------------------------------------------
// Usage: drive cmd and raise start; the word is taken at an edge where busy is
// low. Exactly one result word appears on res with done high for one cycle;
// the receiver cannot hold it off. busy is high from the cycle after
// acceptance until the cycle done is shown, and a new command may be taken at
// the edge that ends that cycle.
// Clear and stage byte finish straight from idle; fetch byte first reads the
// value store, but finishes without a read when the address lies outside the
// values. Insert, update, delete and lookup first run a binary search over the
// directory memory, one read and one compare per step. Insert then shifts the
// directory entries above the new one up one by one and copies the value bytes
// in from staging. Update, delete and compact rebuild the page: each entry kept
// has its value bytes packed into the rebuild memory (dropped entries are
// skipped), then the rebuild memory is copied back into the value store.
// Every memory has one registered read port, so each step reads, then writes.
// Reset empties the page and the staging buffer; memory contents are left
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
module slotted_page_key_value_store_unit
  import spkv_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t res
);

  localparam int MAX_ENTRIES = (PAGE_BYTES - HEADER_BYTES) / (ENTRY_BYTES + 1);
  localparam int MAX_VALUE   = PAGE_BYTES - HEADER_BYTES - ENTRY_BYTES;
  localparam int DEPTH       = MAX_ENTRIES + 1;
  localparam int DW          = $clog2(DEPTH);
  localparam int AW          = $clog2(PAGE_BYTES);
  localparam int LW          = $clog2(PAGE_BYTES + 1);
  localparam int FW          = LW + 1;
  localparam int SW          = $clog2(MAX_VALUE + 1);
  localparam int SIW         = $clog2(MAX_VALUE);

  typedef struct packed {
    logic [31:0]   key;
    logic [AW-1:0] off;
    logic [LW-1:0] len;
  } ent_t;

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_SRCH   = 17'b00000000000000010,
    S_CMP    = 17'b00000000000000100,
    S_HIT    = 17'b00000000000001000,
    S_SHIFT  = 17'b00000000000010000,
    S_SHW    = 17'b00000000000100000,
    S_COPY   = 17'b00000000001000000,
    S_COPYW  = 17'b00000000010000000,
    S_RB     = 17'b00000000100000000,
    S_RBENT  = 17'b00000001000000000,
    S_RBB    = 17'b00000010000000000,
    S_RBBW   = 17'b00000100000000000,
    S_BK     = 17'b00001000000000000,
    S_BKW    = 17'b00010000000000000,
    S_FETCH  = 17'b00100000000000000,
    S_SPARE1 = 17'b01000000000000000,
    S_SPARE2 = 17'b10000000000000000
  } state_t;

  // registers
  state_t        state, state_next;
  cmd_t          cur, cur_next;
  logic [DW-1:0] count, count_next;
  logic [LW-1:0] lv, lv_next;
  logic [SW-1:0] scount, scount_next;
  logic [DW-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic [DW-1:0] pos, pos_next, idx, idx_next, n, n_next;
  ent_t          ent, ent_next;
  logic [LW-1:0] top, top_next, b, b_next, len, len_next;
  logic [AW-1:0] off, off_next;
  logic          from_stg, from_stg_next;
  logic          fin;
  res_t          res_next;

  logic [DW-1:0] mid_c;
  logic [FW-1:0] dir_end, free_c, dir_end_n, free_n;
  logic          hit_c, is_pos;
  logic [LW:0]   src_addr;
  logic [LW-1:0] rb_len;

  // memories
  ent_t          dir_mem [DEPTH];
  logic [7:0]    vst_mem [PAGE_BYTES];
  logic [7:0]    rbd_mem [PAGE_BYTES];
  logic [7:0]    stg_mem [MAX_VALUE];

  ent_t          dir_rdata, dir_wdata;
  logic [DW-1:0] dir_raddr, dir_waddr;
  logic          dir_we;
  logic [7:0]    vst_rdata, vst_wdata;
  logic [AW-1:0] vst_raddr, vst_waddr;
  logic          vst_we;
  logic [7:0]    rbd_rdata, rbd_wdata;
  logic [AW-1:0] rbd_raddr, rbd_waddr;
  logic          rbd_we;
  logic [7:0]    stg_rdata;
  logic [SIW-1:0] stg_raddr;
  logic          stg_we;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rdata <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (vst_we) vst_mem[vst_waddr] <= vst_wdata;
    vst_rdata <= vst_mem[vst_raddr];
  end

  always_ff @(posedge clk) begin
    if (rbd_we) rbd_mem[rbd_waddr] <= rbd_wdata;
    rbd_rdata <= rbd_mem[rbd_raddr];
  end

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[scount[SIW-1:0]] <= cmd.data_byte;
    stg_rdata <= stg_mem[stg_raddr];
  end

  assign mid_c   = lo + ((hi - lo) >> 1);
  assign dir_end = FW'(HEADER_BYTES) + (FW'(count) << 3);
  assign free_c  = (FW'(lv) > dir_end) ? FW'(lv) - dir_end : '0;
  assign hit_c   = (pos < count) && (dir_rdata.key == cur.key);
  assign is_pos  = (idx == pos);
  assign src_addr = (LW+1)'(off) + (LW+1)'(b);
  assign rb_len  = ((cur.func == FN_UPDATE) && is_pos) ? LW'(scount) : dir_rdata.len;
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    count_next    = count;
    lv_next       = lv;
    scount_next   = scount;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    pos_next      = pos;
    idx_next      = idx;
    n_next        = n;
    ent_next      = ent;
    top_next      = top;
    b_next        = b;
    len_next      = len;
    off_next      = off;
    from_stg_next = from_stg;
    fin           = 1'b0;
    res_next      = '0;
    dir_raddr = '0; dir_waddr = '0; dir_wdata = '0; dir_we = 1'b0;
    vst_raddr = '0; vst_waddr = '0; vst_wdata = '0; vst_we = 1'b0;
    rbd_raddr = '0; rbd_waddr = '0; rbd_wdata = '0; rbd_we = 1'b0;
    stg_raddr = '0; stg_we = 1'b0;

    unique case (state)
      S_IDLE: begin
        vst_raddr = AW'(cmd.byte_address);
        if (start) begin
          cur_next = cmd;
          lo_next  = '0;
          hi_next  = count;
          unique case (func_t'(cmd.func))
            FN_CLEAR: begin
              count_next  = '0;
              lv_next     = LW'(PAGE_BYTES);
              scount_next = '0;
              fin = 1'b1;
            end
            FN_STAGE: begin
              if (scount >= SW'(MAX_VALUE)) res_next.status = ST_STAGING_FULL;
              else begin
                stg_we      = 1'b1;
                scount_next = scount + 1'b1;
              end
              fin = 1'b1;
            end
            FN_COMPACT: begin
              idx_next   = '0;
              n_next     = '0;
              top_next   = LW'(PAGE_BYTES);
              state_next = S_RB;
            end
            FN_FETCH: begin
              if ((FW'(cmd.byte_address) < FW'(lv)) ||
                  (FW'(cmd.byte_address) >= FW'(PAGE_BYTES))) begin
                res_next.status = ST_UNWRITTEN;
                fin = 1'b1;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: state_next = S_SRCH;
          endcase
        end
      end

      S_FETCH: begin
        res_next.data_out = vst_rdata;
        fin = 1'b1;
        state_next = S_IDLE;
      end

      S_SRCH: begin
        if (lo < hi) begin
          dir_raddr  = mid_c;
          mid_next   = mid_c;
          state_next = S_CMP;
        end else begin
          dir_raddr  = lo;
          pos_next   = lo;
          state_next = S_HIT;
        end
      end

      S_CMP: begin
        if (dir_rdata.key < cur.key) lo_next = mid + 1'b1;
        else hi_next = mid;
        state_next = S_SRCH;
      end

      S_HIT: begin
        ent_next   = dir_rdata;
        state_next = S_IDLE;
        unique case (func_t'(cur.func))
          FN_INSERT: begin
            if (scount == '0) begin
              res_next.status = ST_EMPTY; scount_next = '0; fin = 1'b1;
            end else if (hit_c) begin
              res_next.status = ST_DUPLICATE; scount_next = '0; fin = 1'b1;
            end else if ((FW'(ENTRY_BYTES) + FW'(scount) > free_c) ||
                         (count >= DW'(MAX_ENTRIES)) || (LW'(scount) > lv)) begin
              res_next.status = ST_NO_SPACE; scount_next = '0; fin = 1'b1;
            end else begin
              len_next   = LW'(scount);
              top_next   = lv - LW'(scount);
              idx_next   = count;
              state_next = S_SHIFT;
            end
          end
          FN_UPDATE: begin
            if (scount == '0) begin
              res_next.status = ST_EMPTY; scount_next = '0; fin = 1'b1;
            end else if (!hit_c) begin
              res_next.status = ST_NOT_FOUND; scount_next = '0; fin = 1'b1;
            end else if (FW'(scount) > free_c + FW'(dir_rdata.len)) begin
              res_next.status = ST_NO_SPACE; scount_next = '0; fin = 1'b1;
            end else begin
              idx_next = '0; n_next = '0; top_next = LW'(PAGE_BYTES);
              state_next = S_RB;
            end
          end
          FN_DELETE: begin
            if (!hit_c) begin
              res_next.status = ST_NOT_FOUND; fin = 1'b1;
            end else begin
              idx_next = '0; n_next = '0; top_next = LW'(PAGE_BYTES);
              state_next = S_RB;
            end
          end
          default: begin
            if (hit_c) begin
              res_next.entry_index = 9'(pos);
              res_next.value_addr  = 12'(dir_rdata.off);
              res_next.value_size  = 12'(dir_rdata.len);
              if (FW'(dir_rdata.len) > FW'(cur.read_limit)) res_next.status = ST_TOO_SMALL;
            end else begin
              res_next.status = ST_NOT_FOUND;
            end
            fin = 1'b1;
          end
        endcase
      end

      // open a hole at pos, moving entries up from the top
      S_SHIFT: begin
        if (idx > pos) begin
          dir_raddr  = idx - 1'b1;
          state_next = S_SHW;
        end else begin
          b_next     = '0;
          state_next = S_COPY;
        end
      end

      S_SHW: begin
        dir_we     = 1'b1;
        dir_waddr  = idx;
        dir_wdata  = dir_rdata;
        idx_next   = idx - 1'b1;
        state_next = S_SHIFT;
      end

      S_COPY: begin
        if (b < len) begin
          stg_raddr  = b[SIW-1:0];
          state_next = S_COPYW;
        end else begin
          dir_we      = 1'b1;
          dir_waddr   = pos;
          dir_wdata   = '{key: cur.key, off: top[AW-1:0], len: len};
          count_next  = count + 1'b1;
          lv_next     = top;
          scount_next = '0;
          fin         = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_COPYW: begin
        vst_we     = 1'b1;
        vst_waddr  = AW'(top + b);
        vst_wdata  = stg_rdata;
        b_next     = b + 1'b1;
        state_next = S_COPY;
      end

      // repack values downward in key order
      S_RB: begin
        if (idx < count) begin
          dir_raddr  = idx;
          state_next = S_RBENT;
        end else begin
          b_next     = top;
          state_next = S_BK;
        end
      end

      S_RBENT: begin
        if ((cur.func == FN_DELETE) && is_pos) begin
          idx_next   = idx + 1'b1;
          state_next = S_RB;
        end else begin
          len_next      = (rb_len > top) ? top : rb_len;
          top_next      = top - ((rb_len > top) ? top : rb_len);
          off_next      = dir_rdata.off;
          ent_next      = dir_rdata;
          from_stg_next = (cur.func == FN_UPDATE) && is_pos;
          b_next        = '0;
          state_next    = S_RBB;
        end
      end

      S_RBB: begin
        if (b < len) begin
          stg_raddr  = b[SIW-1:0];
          vst_raddr  = src_addr[AW-1:0];
          state_next = S_RBBW;
        end else begin
          dir_we     = 1'b1;
          dir_waddr  = n;
          dir_wdata  = '{key: ent.key, off: top[AW-1:0], len: len};
          n_next     = n + 1'b1;
          idx_next   = idx + 1'b1;
          state_next = S_RB;
        end
      end

      S_RBBW: begin
        rbd_we    = 1'b1;
        rbd_waddr = AW'(top + b);
        if (from_stg) rbd_wdata = stg_rdata;
        else if (src_addr < (LW+1)'(PAGE_BYTES)) rbd_wdata = vst_rdata;
        else rbd_wdata = '0;
        b_next     = b + 1'b1;
        state_next = S_RBB;
      end

      S_BK: begin
        if (b < LW'(PAGE_BYTES)) begin
          rbd_raddr  = b[AW-1:0];
          state_next = S_BKW;
        end else begin
          lv_next    = top;
          count_next = n;
          if (cur.func == FN_UPDATE) scount_next = '0;
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_BKW: begin
        vst_we     = 1'b1;
        vst_waddr  = AW'(b - 1'b1 + 1'b1);
        vst_wdata  = rbd_rdata;
        b_next     = b + 1'b1;
        state_next = S_BK;
      end

      default: state_next = S_IDLE;
    endcase

    // page totals after the command
    dir_end_n = FW'(HEADER_BYTES) + (FW'(count_next) << 3);
    free_n    = (FW'(lv_next) > dir_end_n) ? FW'(lv_next) - dir_end_n : '0;
    res_next.entry_total = 9'(count_next);
    res_next.free_space  = 12'(free_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      lv     <= LW'(PAGE_BYTES);
      scount <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      lv     <= lv_next;
      scount <= scount_next;
      done   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    pos      <= pos_next;
    idx      <= idx_next;
    n        <= n_next;
    ent      <= ent_next;
    top      <= top_next;
    b        <= b_next;
    len      <= len_next;
    off      <= off_next;
    from_stg <= from_stg_next;
    if (fin) res <= res_next;
  end

endmodule

// File: dv/slotted_page_key_value_store_unit_test.sv
// ----------------------------------------------------------------------------
// slotted_page_key_value_store_unit_test
// Drives page commands with bursty start timing into the leaf page unit.
// Every command is mirrored in a local copy of the page. Each done word is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module slotted_page_key_value_store_unit_test;
  import spkv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE      = PAGE_BYTES_DEF;
  localparam int HDR       = HEADER_BYTES_DEF;
  localparam int SLOTS     = (PAGE - HDR) / (ENTRY_BYTES + 1);
  localparam int MAX_VAL   = PAGE - HDR - ENTRY_BYTES;
  localparam int NUM_CMDS  = 1950;
  localparam longint CYCLE_LIMIT = 150000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cmd_t cmd = '0;
  res_t res;

  slotted_page_key_value_store_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .res(res)
  );

  always #10 clk = ~clk;

  // local copy of the page
  bit [31:0] dir_key[SLOTS+1];
  int        dir_off[SLOTS+1];
  int        dir_len[SLOTS+1];
  bit [7:0]  page_mem[PAGE];
  bit [7:0]  pack_mem[PAGE];
  bit [7:0]  stage_buf[MAX_VAL];
  int        n_entries;
  int        low_mark;
  int        stage_len;

  res_t   expected_q[$];
  int     mismatches;
  longint cycles;
  int     burst_left;
  int     sent;

  function automatic int free_bytes();
    int dir_end;
    dir_end = HDR + n_entries * ENTRY_BYTES;
    return (low_mark > dir_end) ? low_mark - dir_end : 0;
  endfunction

  function automatic int key_position(bit [31:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (dir_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // repack values from the page top in key order; -1 means no entry
  function automatic void repack(int omit_at, int replace_at);
    int top, n, len, off;
    top = PAGE;
    n = 0;
    for (int i = 0; i < n_entries; i++) begin
      if (i == omit_at) continue;
      len = (i == replace_at) ? stage_len : dir_len[i];
      if (len > top) len = top;
      top -= len;
      off = dir_off[i];
      for (int b = 0; b < len; b++)
        pack_mem[top+b] = (i == replace_at) ? stage_buf[b] : page_mem[off+b];
      dir_key[n] = dir_key[i];
      dir_off[n] = top;
      dir_len[n] = len;
      n++;
    end
    for (int a = top; a < PAGE; a++) page_mem[a] = pack_mem[a];
    low_mark = top;
    n_entries = n;
  endfunction

  function automatic res_t page_result(cmd_t c);
    res_t r;
    status_t st;
    int pos, len, base;
    bit hit;
    r = '0;
    st = ST_OK;
    pos = key_position(c.key);
    hit = (pos < n_entries) && (dir_key[pos] == c.key);
    case (func_t'(c.func))
      FN_CLEAR: begin
        n_entries = 0;
        low_mark = PAGE;
        stage_len = 0;
      end
      FN_STAGE: begin
        if (stage_len >= MAX_VAL) st = ST_STAGING_FULL;
        else begin
          stage_buf[stage_len] = c.data_byte;
          stage_len++;
        end
      end
      FN_INSERT: begin
        len = stage_len;
        if (len == 0) st = ST_EMPTY;
        else if (hit) st = ST_DUPLICATE;
        else if (ENTRY_BYTES + len > free_bytes() || n_entries >= SLOTS || len > low_mark)
          st = ST_NO_SPACE;
        else begin
          base = low_mark - len;
          for (int i = n_entries; i > pos; i--) begin
            dir_key[i] = dir_key[i-1];
            dir_off[i] = dir_off[i-1];
            dir_len[i] = dir_len[i-1];
          end
          for (int i = 0; i < len; i++) page_mem[base+i] = stage_buf[i];
          dir_key[pos] = c.key;
          dir_off[pos] = base;
          dir_len[pos] = len;
          n_entries++;
          low_mark = base;
        end
        stage_len = 0;
      end
      FN_UPDATE: begin
        if (stage_len == 0) st = ST_EMPTY;
        else if (!hit) st = ST_NOT_FOUND;
        else if (stage_len > free_bytes() + dir_len[pos]) st = ST_NO_SPACE;
        else repack(-1, pos);
        stage_len = 0;
      end
      FN_DELETE: begin
        if (hit) repack(pos, -1);
        else st = ST_NOT_FOUND;
      end
      FN_COMPACT: repack(-1, -1);
      FN_LOOKUP: begin
        if (hit) begin
          r.entry_index = 9'(pos);
          r.value_addr  = 12'(dir_off[pos]);
          r.value_size  = 12'(dir_len[pos]);
          if (dir_len[pos] > int'(c.read_limit)) st = ST_TOO_SMALL;
        end else st = ST_NOT_FOUND;
      end
      default: begin
        if (int'(c.byte_address) < low_mark) st = ST_UNWRITTEN;
        else r.data_out = page_mem[c.byte_address];
      end
    endcase
    r.status      = st;
    r.entry_total = 9'(n_entries);
    r.free_space  = 12'(free_bytes());
    return r;
  endfunction

  // send one command word; bursts of back-to-back words with random gaps
  task automatic send(func_t f, bit [31:0] k = 0, bit [7:0] d = 0,
                      bit [12:0] lim = 0, bit [11:0] addr = 0);
    cmd_t c;
    int gap;
    c.func = f;
    c.key = k;
    c.data_byte = d;
    c.read_limit = lim;
    c.byte_address = addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(page_result(c));
    sent++;
    @(negedge clk);
  endtask

  task automatic stage_random(int n);
    for (int i = 0; i < n; i++) send(FN_STAGE, 0, 8'($urandom_range(0, 255)));
  endtask

  function automatic bit [31:0] pick_key();
    if (n_entries > 0 && $urandom_range(0, 3) != 0)
      return dir_key[$urandom_range(0, n_entries - 1)];
    return ($urandom_range(0, 1) == 1) ? $urandom() : 32'($urandom_range(0, 63));
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", res);
      end else begin
        e = expected_q.pop_front();
        if (res !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d index %0d/%0d addr %0d/%0d size %0d/%0d",
                     e.status, res.status, e.entry_index, res.entry_index,
                     e.value_addr, res.value_addr, e.value_size, res.value_size);
          if (mismatches <= 10)
            $display("          data %0d/%0d total %0d/%0d free %0d/%0d (expected/actual)",
                     e.data_out, res.data_out, e.entry_total, res.entry_total,
                     e.free_space, res.free_space);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("slotted_page_key_value_store_unit_test failed");
      $finish;
    end
  end

  task automatic test_empty_page();
    send(FN_LOOKUP, 32'h0, 0, 13'd4096);
    send(FN_FETCH, 0, 0, 0, 12'd4095);
    send(FN_COMPACT);
    send(FN_DELETE, 32'h5);
    send(FN_UPDATE, 32'h5);
    send(FN_INSERT, 32'h5);
  endtask

  task automatic test_basic_ops();
    stage_random(3);
    send(FN_INSERT, 32'hFFFF_FFFF);
    stage_random(2);
    send(FN_INSERT, 32'h0);
    stage_random(1);
    send(FN_INSERT, 32'hFFFF_FFFF);   // duplicate
    send(FN_LOOKUP, 32'hFFFF_FFFF, 0, 13'd2);   // too long for the limit
    send(FN_LOOKUP, 32'h0, 0, 13'd4096);
    send(FN_LOOKUP, 32'h1234_5678, 0, 13'd4096);
    send(FN_FETCH, 0, 0, 0, 12'd4091);
    send(FN_FETCH, 0, 0, 0, 12'd4095);
    stage_random(4);
    send(FN_UPDATE, 32'h0);
    stage_random(1);
    send(FN_UPDATE, 32'h77);
    send(FN_DELETE, 32'hFFFF_FFFF);
    send(FN_COMPACT);
    send(FN_CLEAR);
  endtask

  task automatic test_value_bounds();
    stage_random(200);
    send(FN_INSERT, 32'hA5A5_5A5A);
    send(FN_FETCH, 0, 0, 0, 12'(PAGE - 201));   // just below the value
    send(FN_FETCH, 0, 0, 0, 12'(PAGE - 200));
    send(FN_LOOKUP, 32'hA5A5_5A5A, 0, 13'd199);
    send(FN_LOOKUP, 32'hA5A5_5A5A, 0, 13'd200);
    stage_random(120);
    send(FN_UPDATE, 32'hA5A5_5A5A);
    stage_random(8);
    send(FN_DELETE, 32'hA5A5_5A5A);
    stage_random(4);
    send(FN_INSERT, 32'h3);
    stage_random(2);
    send(FN_UPDATE, 32'h3);
    send(FN_CLEAR);
  endtask

  task automatic test_full_directory();
    for (int i = 0; i < SLOTS; i++) begin
      stage_random(1);
      send(FN_INSERT, 32'(i * 2 + 1));
    end
    stage_random(1);
    send(FN_INSERT, 32'h8000_0000);       // no free slot
    stage_random(7);
    send(FN_UPDATE, 32'd1);               // larger than free plus old value
    send(FN_LOOKUP, 32'(2 * SLOTS - 1), 0, 13'd1);
    send(FN_COMPACT);
    send(FN_DELETE, 32'd301);
    stage_random(1);
    send(FN_INSERT, 32'd300);
    send(FN_FETCH, 0, 0, 0, 12'd4095);
    send(FN_CLEAR);
  endtask

  task automatic test_random_traffic();
    int r, n;
    while (sent < NUM_CMDS) begin
      if (n_entries > 100) send(FN_CLEAR);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        stage_random(n);
        if ($urandom_range(0, 9) < 7)
          send(FN_INSERT, ($urandom_range(0, 4) == 0) ? pick_key() : $urandom());
        else send(FN_UPDATE, pick_key());
      end else if (r < 65) begin
        send(FN_LOOKUP, pick_key(), 0,
             ($urandom_range(0, 1) == 1) ? 13'($urandom_range(0, 16))
                                         : 13'($urandom_range(0, 4096)));
      end else if (r < 80) begin
        send(FN_FETCH, 0, 0, 0,
             ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                         : 12'($urandom_range(low_mark - 4, 4095)));
      end else if (r < 87) send(FN_DELETE, pick_key());
      else if (r < 90) send(FN_COMPACT);
      else if (r < 95) send(($urandom_range(0, 1) == 1) ? FN_INSERT : FN_UPDATE, pick_key());
      else if (r < 99) stage_random(1);
      else send(FN_CLEAR);
    end
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    sent = 0;
    n_entries = 0;
    low_mark = PAGE;
    stage_len = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_page();
    test_basic_ops();
    test_value_bounds();
    test_full_directory();
    test_random_traffic();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("slotted_page_key_value_store_unit_test passed");
    else
      $display("slotted_page_key_value_store_unit_test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/spkv_pkg.sv
rtl/slotted_page_key_value_store_unit.sv
dv/slotted_page_key_value_store_unit_test.sv
